[sv/srsp_pkg.sv]
// srsp_pkg: shared constants, types and helpers for the scene record stream parser.
// No dependencies.
`default_nettype none
package srsp_pkg;
    localparam int unsigned COLOR_DEPTH_DEF = 256;
    localparam logic [31:0] SCENE_MAGIC = 32'hDEADBEEF;

    localparam logic [3:0] SEC_HEADER  = 4'd0;
    localparam logic [3:0] SEC_COLORS  = 4'd1;
    localparam logic [3:0] SEC_TILES   = 4'd2;
    localparam logic [3:0] SEC_SCREENS = 4'd3;
    localparam logic [3:0] SEC_CHILD   = 4'd4;
    localparam logic [3:0] SEC_GLYPHS  = 4'd5;
    localparam logic [3:0] SEC_FONTS   = 4'd6;
    localparam logic [3:0] SEC_TEXTS   = 4'd7;
    localparam logic [3:0] SEC_BUNDLES = 4'd8;

    localparam logic [3:0] FLD_COUNT = 4'd0;
    localparam logic [3:0] FLD_POOL  = 4'd15;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_MAGIC    = 3'd1;
    localparam logic [2:0] ERR_TRUNC    = 3'd2;
    localparam logic [2:0] ERR_TILETYPE = 3'd3;
    localparam logic [2:0] ERR_COMPR    = 3'd4;
    localparam logic [2:0] ERR_POOL     = 3'd5;
    localparam logic [2:0] ERR_HANDLE   = 3'd6;
    localparam logic [2:0] ERR_COLOROVF = 3'd7;

    typedef struct packed {
        logic [3:0]  section;
        logic [3:0]  field_code;
        logic [15:0] record_index;
        logic [31:0] field_value;
        logic [15:0] derived_edge;
        logic        lookup;     // tile color handle: rgba from color store
        logic [2:0]  error_code;
        logic        scene_done;
    } t_result;

    // Field length in bytes, modulo 4 (a dword reads as 0).
    function automatic logic [1:0] field_len(input logic [3:0] sec, input logic [3:0] step);
        logic [1:0] len;
        len = 2'd2;
        if (sec == SEC_HEADER) len = 2'd0;
        else if (step == FLD_COUNT || step == FLD_POOL) len = 2'd2;
        else begin
            case (sec)
                SEC_TILES: begin
                    if (step == 4'd9 || step == 4'd11 || step == 4'd14) len = 2'd1;
                    else if (step == 4'd12) len = 2'd0;
                end
                SEC_GLYPHS: begin
                    if (step == 4'd7) len = 2'd0;
                    else if (step == 4'd9) len = 2'd1;
                end
                SEC_TEXTS: if (step == 4'd6 || step == 4'd7) len = 2'd1;
                SEC_BUNDLES: len = 2'd0;
                default: len = 2'd2;
            endcase
        end
        return len;
    endfunction

    function automatic logic [31:0] expand_color(input logic [15:0] c);
        logic [31:0] r;
        r = {4'(c[15:12]), 4'(c[15:12]), 4'(c[11:8]), 4'(c[11:8]),
             4'(c[7:4]), 4'(c[7:4]), 4'(c[3:0]), 4'(c[3:0])};
        return r;
    endfunction
endpackage
`default_nettype wire

[sv/srsp_colors.sv]
// srsp_colors: color table memory with registered read and RGBA8 expansion.
// Depends on srsp_pkg.
`default_nettype none
module srsp_colors #(
    parameter int unsigned COLOR_DEPTH = srsp_pkg::COLOR_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_we,
    input  wire logic [$clog2(COLOR_DEPTH)-1:0] i_waddr,
    input  wire logic [15:0]                    i_wdata,
    input  wire logic                           i_re,
    input  wire logic [$clog2(COLOR_DEPTH)-1:0] i_raddr,
    output logic [31:0]                         o_rgba
);
    logic [15:0] r_mem [COLOR_DEPTH];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) r_rdata <= r_mem[i_raddr];
    end

    assign o_rgba = srsp_pkg::expand_color(r_rdata);
endmodule
`default_nettype wire

[sv/scene_record_stream_parser.sv]
// scene_record_stream_parser: top level, byte parser and output register.
// Depends on srsp_pkg and srsp_colors.
`default_nettype none
// Usage:
//   Input channel (i_valid/o_ready) carries one image byte per request, with
//   i_first_byte marking byte position zero; it restarts the parser.
//   Output channel (o_valid/i_ready) carries one tagged field per request:
//   section, field code, record index, value, tile edge, tile RGBA, error
//   and scene-done flag. Bytes inside a field produce no request.
//   Throughput: one byte per cycle while the output is not stalled. The result
//   of a byte is registered and appears on the output in the cycle after the byte is accepted.
//   The color table lookup for a tile handle is a synchronous memory read
//   launched in the accept cycle; its data is expanded at the output.
//   Receiver stall: the output register holds its request; the input side
//   keeps accepting while the output is empty or being drained this cycle
//   (one-deep output stage, ready passes through combinationally).
//   Reset clears the parser to the header; the color table is not cleared
//   and an unwritten color entry reads as garbage.
//   After an error halt or a completed scene, bytes are consumed silently
//   until a byte with i_first_byte set arrives.
module scene_record_stream_parser #(
    parameter int unsigned COLOR_DEPTH = srsp_pkg::COLOR_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_first_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [3:0]       o_section,
    output logic [3:0]       o_field_code,
    output logic [15:0]      o_record_index,
    output logic [31:0]      o_field_value,
    output logic [15:0]      o_derived_edge,
    output logic [31:0]      o_tile_rgba,
    output logic [2:0]       o_error_code,
    output logic             o_scene_done
);
    localparam int unsigned AW = $clog2(COLOR_DEPTH);

    // parser state
    logic [3:0]  r_sec, n_sec;
    logic [3:0]  r_step, n_step;
    logic [1:0]  r_bif, n_bif;
    logic [31:0] r_acc, n_acc;
    logic [15:0] r_rec, n_rec;
    logic [15:0] r_tot, n_tot;
    logic [15:0] r_iwc, n_iwc;
    logic [31:0] r_pos, n_pos;
    logic [31:0] r_len, n_len;
    logic [15:0] r_left, n_left, r_top, n_top;
    logic [15:0] r_ctot, n_ctot;
    logic        r_halt, n_halt;

    logic        r_ovalid;
    srsp_pkg::t_result r_res, n_res;
    logic        n_emit;

    logic        acc_in;
    logic        c_we, c_re;
    logic [AW-1:0] c_waddr, c_raddr;
    logic [31:0] c_rgba;

    assign o_ready = !r_ovalid || i_ready;
    assign acc_in  = i_valid && o_ready;

    always_comb begin
        logic [3:0]  sec, step;
        logic [1:0]  bif;
        logic [31:0] acc, val;
        logic [15:0] rec, iwc;
        logic [31:0] len;
        logic        halt, last, endsec;
        logic [3:0]  nsec;

        sec = r_sec; step = r_step; bif = r_bif; acc = r_acc; rec = r_rec;
        iwc = r_iwc; len = r_len; halt = r_halt;
        n_tot = r_tot; n_pos = r_pos; n_left = r_left; n_top = r_top;
        n_ctot = r_ctot;
        if (i_first_byte) begin
            sec = srsp_pkg::SEC_HEADER; step = 4'd1; bif = 2'd0; acc = '0;
            rec = '0; iwc = '0; len = '0; halt = 1'b0;
            n_tot = '0; n_pos = '0; n_left = '0; n_top = '0; n_ctot = '0;
        end
        n_emit = 1'b0;
        c_we = 1'b0; c_re = 1'b0;
        c_waddr = rec[AW-1:0];
        c_raddr = '0;
        val = '0; last = 1'b0; endsec = 1'b0; nsec = sec + 4'd1;
        n_res = '0;
        n_res.section = sec; n_res.field_code = step; n_res.record_index = rec;

        if (!halt) begin
            if (sec != srsp_pkg::SEC_HEADER && n_pos >= len) begin
                halt = 1'b1; n_emit = 1'b1;
                n_res.error_code = srsp_pkg::ERR_TRUNC;
            end else begin
                if (n_pos != 32'hFFFF_FFFF) n_pos = n_pos + 32'd1;
                acc = acc | ({24'd0, i_data_byte} << {bif, 3'd0});
                bif = bif + 2'd1;
                if (bif == srsp_pkg::field_len(sec, step)) begin
                    val = acc; acc = '0; bif = 2'd0; n_emit = 1'b1;
                    n_res.field_value = val;
                    if (sec == srsp_pkg::SEC_HEADER) begin
                        if (step == 4'd1) begin
                            if (val != srsp_pkg::SCENE_MAGIC) begin
                                n_res.error_code = srsp_pkg::ERR_MAGIC; halt = 1'b1;
                            end else step = 4'd2;
                        end else begin
                            len = val; sec = srsp_pkg::SEC_COLORS;
                            rec = '0; step = srsp_pkg::FLD_COUNT;
                        end
                    end else if (step == srsp_pkg::FLD_POOL) begin
                        iwc = val[15:0]; step = srsp_pkg::FLD_COUNT;
                    end else if (step == srsp_pkg::FLD_COUNT) begin
                        n_tot = val[15:0]; rec = '0;
                        if (sec == srsp_pkg::SEC_COLORS && val > 32'(COLOR_DEPTH)) begin
                            n_res.error_code = srsp_pkg::ERR_COLOROVF; halt = 1'b1;
                        end else if (sec == srsp_pkg::SEC_TEXTS && val != 0 && iwc == 0) begin
                            n_res.error_code = srsp_pkg::ERR_POOL; halt = 1'b1;
                        end else begin
                            if (sec == srsp_pkg::SEC_COLORS) n_ctot = val[15:0];
                            if (val == 0) endsec = 1'b1;
                            else step = 4'd1;
                        end
                    end else begin
                        case (sec)
                            srsp_pkg::SEC_COLORS: begin
                                if (32'(rec) < 32'(COLOR_DEPTH)) c_we = 1'b1;
                                last = 1'b1;
                            end
                            srsp_pkg::SEC_TILES: begin
                                if (step == 4'd5) n_left = val[15:0];
                                else if (step == 4'd6) n_top = val[15:0];
                                else if (step == 4'd7)
                                    n_res.derived_edge = r_left + val[15:0] - 16'd1;
                                else if (step == 4'd8)
                                    n_res.derived_edge = r_top + val[15:0] - 16'd1;
                                else if (step == 4'd10) begin
                                    if (val < 32'(r_ctot) && val < 32'(COLOR_DEPTH)) begin
                                        c_re = 1'b1; c_raddr = val[AW-1:0];
                                        n_res.lookup = 1'b1;
                                    end else n_res.error_code = srsp_pkg::ERR_HANDLE;
                                end else if (step == 4'd11) begin
                                    if (val == 0) last = 1'b1;
                                    else if (val != 1) begin
                                        n_res.error_code = srsp_pkg::ERR_TILETYPE;
                                        halt = 1'b1;
                                    end
                                end else if (step == 4'd14) begin
                                    if (val >= 2) begin
                                        n_res.error_code = srsp_pkg::ERR_COMPR; halt = 1'b1;
                                    end else last = 1'b1;
                                end
                            end
                            srsp_pkg::SEC_SCREENS: last = (step == 4'd2);
                            srsp_pkg::SEC_CHILD:   last = 1'b1;
                            srsp_pkg::SEC_GLYPHS: begin
                                if (step == 4'd9) begin
                                    if (val >= 2) begin
                                        n_res.error_code = srsp_pkg::ERR_COMPR; halt = 1'b1;
                                    end else last = 1'b1;
                                end
                            end
                            srsp_pkg::SEC_FONTS: last = (step == 4'd3);
                            srsp_pkg::SEC_TEXTS: begin
                                if (step == 4'd1) iwc = val[15:0];
                                else if (step == 4'd7) last = (iwc == 0);
                                else if (step == 4'd8) begin
                                    iwc = iwc - 16'd1;
                                    last = (iwc == 0);
                                end
                            end
                            default: last = (step == 4'd2);
                        endcase
                        if (!halt) begin
                            if (last) begin
                                rec = rec + 16'd1;
                                if (rec >= n_tot) endsec = 1'b1;
                                else step = 4'd1;
                            end else if (!(sec == srsp_pkg::SEC_TEXTS && step == 4'd8))
                                step = step + 4'd1;
                        end
                    end
                    if (endsec) begin
                        if (nsec > srsp_pkg::SEC_BUNDLES) begin
                            halt = 1'b1; n_res.scene_done = 1'b1;
                        end else begin
                            sec = nsec; rec = '0;
                            step = (nsec == srsp_pkg::SEC_TEXTS) ? srsp_pkg::FLD_POOL
                                                                 : srsp_pkg::FLD_COUNT;
                        end
                    end
                end
            end
        end
        n_sec = sec; n_step = step; n_bif = bif; n_acc = acc; n_rec = rec;
        n_iwc = iwc; n_len = len; n_halt = halt;
    end

    srsp_colors #(.COLOR_DEPTH(COLOR_DEPTH)) u_colors (
        .i_clk   (i_clk),
        .i_we    (acc_in && c_we),
        .i_waddr (c_waddr),
        .i_wdata (n_acc == '0 ? r_acc[15:0] | {i_data_byte, 8'd0} : 16'd0),
        .i_re    (acc_in && c_re),
        .i_raddr (c_raddr),
        .o_rgba  (c_rgba)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec <= srsp_pkg::SEC_HEADER; r_step <= 4'd1; r_bif <= '0; r_acc <= '0;
            r_rec <= '0; r_tot <= '0; r_iwc <= '0; r_pos <= '0; r_len <= '0;
            r_left <= '0; r_top <= '0; r_ctot <= '0; r_halt <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (acc_in) begin
                r_sec <= n_sec; r_step <= n_step; r_bif <= n_bif; r_acc <= n_acc;
                r_rec <= n_rec; r_tot <= n_tot; r_iwc <= n_iwc; r_pos <= n_pos;
                r_len <= n_len; r_left <= n_left; r_top <= n_top; r_ctot <= n_ctot;
                r_halt <= n_halt;
            end
            if (acc_in) r_ovalid <= n_emit;
            else if (i_ready) r_ovalid <= 1'b0;
        end
    end

    // The color memory's read register holds while the result waits,
    // since a read is only launched on an accepted byte.
    always_ff @(posedge i_clk) begin
        if (acc_in) r_res <= n_res;
    end

    assign o_valid        = r_ovalid;
    assign o_section      = r_res.section;
    assign o_field_code   = r_res.field_code;
    assign o_record_index = r_res.record_index;
    assign o_field_value  = r_res.field_value;
    assign o_derived_edge = r_res.derived_edge;
    assign o_tile_rgba    = r_res.lookup ? c_rgba : 32'd0;
    assign o_error_code   = r_res.error_code;
    assign o_scene_done   = r_res.scene_done;
endmodule
`default_nettype wire

[tb/sv/tb_scene_record_stream_parser.sv]
// Self-checking testbench for scene_record_stream_parser: it streams scene images and checks
// every tagged field against an in-bench predictor. Depends on srsp_pkg and the parser RTL.
`default_nettype none
module tb_scene_record_stream_parser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CDEPTH = srsp_pkg::COLOR_DEPTH_DEF;

    // kinds of damage a generated scene can carry
    localparam int FL_NONE     = 0;
    localparam int FL_MAGIC    = 1;
    localparam int FL_TRUNC    = 2;
    localparam int FL_TILETYPE = 3;
    localparam int FL_COMPR    = 4;
    localparam int FL_POOL     = 5;
    localparam int FL_HANDLE   = 6;
    localparam int FL_COLOROVF = 7;
    localparam int FL_NOISE    = 8;

    typedef struct packed {
        logic [3:0]  section;
        logic [3:0]  field_code;
        logic [15:0] record_index;
        logic [31:0] field_value;
        logic [15:0] derived_edge;
        logic [31:0] tile_rgba;
        logic [2:0]  error_code;
        logic        scene_done;
    } t_field_rec;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_first_byte = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [3:0]  o_section;
    logic [3:0]  o_field_code;
    logic [15:0] o_record_index;
    logic [31:0] o_field_value;
    logic [15:0] o_derived_edge;
    logic [31:0] o_tile_rgba;
    logic [2:0]  o_error_code;
    logic        o_scene_done;

    scene_record_stream_parser uut (.*);

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // pending byte requests: {first_byte, data_byte}
    logic [8:0]  byte_reqs[$];
    logic [7:0]  img[$];
    t_field_rec  field_q[$];
    int          err_count = 0;
    int          issued = 0;
    int          total_items = 0;
    int          pause_at = 0;
    bit          taken = 1'b0;
    int          phase = 0;
    int          idle_pct[4]  = '{0, 75, 0, 18};
    int          stall_pct[4] = '{0, 0, 75, 18};

    // ---------------------------------------------------------------- predictor
    logic [3:0]  p_sec;
    logic [3:0]  p_step;
    logic [1:0]  p_bif;
    logic [31:0] p_acc;
    logic [15:0] p_rec;
    logic [15:0] p_total;
    logic [15:0] p_words;
    logic [31:0] p_pos;
    logic [31:0] p_len;
    logic [15:0] p_lt[2];
    logic        p_tex;
    logic [15:0] p_colors[CDEPTH];
    logic [15:0] p_ncolors;
    logic        p_halt;

    task automatic clear_parse();
        p_sec = srsp_pkg::SEC_HEADER; p_step = 4'd1; p_bif = 2'd0; p_acc = 32'd0;
        p_rec = 16'd0; p_total = 16'd0; p_words = 16'd0; p_pos = 32'd0;
        p_len = 32'd0; p_lt[0] = 16'd0; p_lt[1] = 16'd0; p_tex = 1'b0;
        p_ncolors = 16'd0; p_halt = 1'b0;
    endtask

    // bytes per field, mod 4 (dwords read 0)
    function automatic logic [1:0] width_of(input logic [3:0] s, input logic [3:0] f);
        if (s == srsp_pkg::SEC_HEADER) return 2'd0;
        if (f == srsp_pkg::FLD_COUNT || f == srsp_pkg::FLD_POOL) return 2'd2;
        case (s)
            srsp_pkg::SEC_TILES:
                return (f == 9 || f == 11 || f == 14) ? 2'd1 : (f == 12) ? 2'd0 : 2'd2;
            srsp_pkg::SEC_GLYPHS:  return (f == 7) ? 2'd0 : (f == 9) ? 2'd1 : 2'd2;
            srsp_pkg::SEC_TEXTS:   return (f == 6 || f == 7) ? 2'd1 : 2'd2;
            srsp_pkg::SEC_BUNDLES: return 2'd0;
            default:               return 2'd2;
        endcase
    endfunction

    function automatic logic open_section(input int s);
        if (s > 8) begin
            p_halt = 1'b1;
            return 1'b1;
        end
        p_sec = 4'(s);
        p_rec = 16'd0;
        p_step = (s == 7) ? srsp_pkg::FLD_POOL : srsp_pkg::FLD_COUNT;
        return 1'b0;
    endfunction

    function automatic logic close_record();
        p_rec = p_rec + 16'd1;
        if (p_rec >= p_total) return open_section(p_sec + 1);
        p_step = 4'd1;
        return 1'b0;
    endfunction

    function automatic logic [31:0] rgba8(input logic [15:0] c);
        return {8'(c[15:12] * 17), 8'(c[11:8] * 17), 8'(c[7:4] * 17), 8'(c[3:0] * 17)};
    endfunction

    task automatic predict_byte(input logic [7:0] b, input logic first);
        t_field_rec r;
        logic [31:0] v;
        logic last;
        if (first) clear_parse();
        if (p_halt) return;
        r = '0;
        r.section = p_sec; r.field_code = p_step; r.record_index = p_rec;
        if (p_sec != srsp_pkg::SEC_HEADER && p_pos >= p_len) begin
            p_halt = 1'b1;
            r.error_code = srsp_pkg::ERR_TRUNC;
            field_q.push_back(r);
            return;
        end
        if (p_pos != 32'hFFFF_FFFF) p_pos++;
        p_acc = p_acc | (32'(b) << (8 * p_bif));
        p_bif = p_bif + 2'd1;
        if (p_bif != width_of(p_sec, p_step)) return;
        v = p_acc;
        p_acc = 32'd0;
        p_bif = 2'd0;
        r.field_value = v;
        last = 1'b0;
        if (p_sec == srsp_pkg::SEC_HEADER) begin
            if (p_step == 4'd1) begin
                if (v != srsp_pkg::SCENE_MAGIC) begin
                    r.error_code = srsp_pkg::ERR_MAGIC;
                    p_halt = 1'b1;
                end else p_step = 4'd2;
            end else begin
                p_len = v;
                void'(open_section(1));
            end
        end else if (p_step == srsp_pkg::FLD_POOL) begin
            p_words = v[15:0];
            p_step = srsp_pkg::FLD_COUNT;
        end else if (p_step == srsp_pkg::FLD_COUNT) begin
            p_total = v[15:0];
            p_rec = 16'd0;
            if (p_sec == srsp_pkg::SEC_COLORS && v > CDEPTH) begin
                r.error_code = srsp_pkg::ERR_COLOROVF;
                p_halt = 1'b1;
            end else if (p_sec == srsp_pkg::SEC_TEXTS && v != 0 && p_words == 0) begin
                r.error_code = srsp_pkg::ERR_POOL;
                p_halt = 1'b1;
            end else begin
                if (p_sec == srsp_pkg::SEC_COLORS) p_ncolors = v[15:0];
                if (v == 0) r.scene_done = open_section(p_sec + 1);
                else p_step = 4'd1;
            end
        end else begin
            case (p_sec)
                srsp_pkg::SEC_COLORS: begin
                    if (p_rec < CDEPTH) p_colors[p_rec] = v[15:0];
                    last = 1'b1;
                end
                srsp_pkg::SEC_TILES: begin
                    if (p_step == 5 || p_step == 6) p_lt[p_step - 5] = v[15:0];
                    else if (p_step == 7 || p_step == 8)
                        r.derived_edge = p_lt[p_step - 7] + v[15:0] - 16'd1;
                    else if (p_step == 10) begin
                        if (v < p_ncolors && v < CDEPTH) r.tile_rgba = rgba8(p_colors[v]);
                        else r.error_code = srsp_pkg::ERR_HANDLE;
                    end else if (p_step == 11) begin
                        if (v == 0) last = 1'b1;
                        else if (v == 1) p_tex = 1'b1;
                        else begin
                            r.error_code = srsp_pkg::ERR_TILETYPE;
                            p_halt = 1'b1;
                        end
                    end else if (p_step == 14) begin
                        if (v >= 2) begin
                            r.error_code = srsp_pkg::ERR_COMPR;
                            p_halt = 1'b1;
                        end else begin
                            p_tex = 1'b0;
                            last = 1'b1;
                        end
                    end
                end
                srsp_pkg::SEC_SCREENS: last = (p_step == 2);
                srsp_pkg::SEC_CHILD:   last = 1'b1;
                srsp_pkg::SEC_GLYPHS: begin
                    if (p_step == 9) begin
                        if (v >= 2) begin
                            r.error_code = srsp_pkg::ERR_COMPR;
                            p_halt = 1'b1;
                        end else last = 1'b1;
                    end
                end
                srsp_pkg::SEC_FONTS: last = (p_step == 3);
                srsp_pkg::SEC_TEXTS: begin
                    if (p_step == 1) p_words = v[15:0];
                    else if (p_step == 7) last = (p_words == 0);
                    else if (p_step == 8) begin
                        p_words = p_words - 16'd1;
                        last = (p_words == 0);
                    end
                end
                default: last = (p_step == 2);
            endcase
            if (!p_halt) begin
                if (last) r.scene_done = close_record();
                else if (!(p_sec == srsp_pkg::SEC_TEXTS && p_step == 8)) p_step = p_step + 4'd1;
            end
        end
        field_q.push_back(r);
    endtask

    // ---------------------------------------------------------------- image builder
    task automatic put8(input logic [7:0] v);
        img.push_back(v);
    endtask
    task automatic put16(input logic [15:0] v);
        put8(v[7:0]); put8(v[15:8]);
    endtask
    task automatic put32(input logic [31:0] v);
        put16(v[15:0]); put16(v[31:16]);
    endtask

    function automatic int pick_count(input bit tiny);
        if (tiny) return 0;
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3);
    endfunction

    // Build one image; damage picks one way to break it.
    task automatic build_scene(input int damage, input bit tiny);
        int nc, nt, n, wc;
        logic [31:0] dlen, total;
        logic [31:0] magic;
        img.delete();
        if (damage == FL_NOISE) begin
            n = $urandom_range(4, 40);
            repeat (n) byte_reqs.push_back({1'b0, 8'($urandom)});
            return;
        end
        // colors
        nc = pick_count(tiny);
        if (!tiny && $urandom_range(0, 40) == 0) nc = CDEPTH;
        if (damage == FL_COLOROVF) begin
            put16(16'(CDEPTH + 1 + $urandom_range(0, 65000)));
            repeat ($urandom_range(0, 6)) put8(8'($urandom));
        end else begin
            put16(16'(nc));
            repeat (nc) put16(16'($urandom));
            // tiles
            nt = pick_count(tiny);
            if (damage == FL_TILETYPE || damage == FL_HANDLE || damage == FL_COMPR) nt = 1 + nt;
            put16(16'(nt));
            for (int t = 0; t < nt; t++) begin
                repeat (8) put16(16'($urandom));
                put8(8'($urandom));
                if (damage == FL_HANDLE && t == 0) put16(16'(nc + $urandom_range(0, 1000)));
                else if (nc > 0 && $urandom_range(0, 9) != 0) put16(16'($urandom_range(0, nc - 1)));
                else put16(16'($urandom));
                if (damage == FL_TILETYPE && t == 0) put8(8'($urandom_range(2, 255)));
                else if ((damage == FL_COMPR && t == 0) || $urandom_range(0, 1)) begin
                    put8(8'd1);
                    put32($urandom);
                    put16(16'($urandom));
                    put8((damage == FL_COMPR && t == 0) ? 8'($urandom_range(2, 255))
                                                       : 8'($urandom_range(0, 1)));
                end else put8(8'd0);
            end
            // screens
            n = pick_count(tiny);
            put16(16'(n));
            repeat (2 * n) put16(16'($urandom));
            // child index
            n = pick_count(tiny);
            put16(16'(n));
            repeat (n) put16(16'($urandom));
            // glyphs
            n = pick_count(tiny);
            put16(16'(n));
            repeat (n) begin
                repeat (6) put16(16'($urandom));
                put32($urandom);
                put16(16'($urandom));
                put8(8'($urandom_range(0, 1)));
            end
            // fonts
            n = pick_count(tiny);
            put16(16'(n));
            repeat (3 * n) put16(16'($urandom));
            // texts: pool length, count, then records with trailing words
            n = pick_count(tiny);
            if (damage == FL_POOL) begin
                put16(16'd0);
                put16(16'($urandom_range(1, 65535)));
            end else begin
                put16((n == 0 && $urandom_range(0, 1)) ? 16'd0 : 16'($urandom_range(1, 65535)));
                put16(16'(n));
                repeat (n) begin
                    wc = $urandom_range(0, 3);
                    put16(16'(wc));
                    repeat (4) put16(16'($urandom));
                    put8(8'($urandom)); put8(8'($urandom));
                    repeat (wc) put16(16'($urandom));
                end
                // bundles
                n = pick_count(tiny);
                put16(16'(n));
                repeat (2 * n) put32($urandom);
            end
        end
        total = 32'(8 + img.size());
        dlen = total;
        if (damage == FL_TRUNC) dlen = $urandom_range(0, total - 1);
        else if ($urandom_range(0, 3) == 0) dlen = total + $urandom_range(0, 1000);
        magic = srsp_pkg::SCENE_MAGIC;
        if (damage == FL_MAGIC) begin
            magic = $urandom;
            if (magic == srsp_pkg::SCENE_MAGIC) magic = ~magic;
        end
        byte_reqs.push_back({1'b1, magic[7:0]});
        byte_reqs.push_back({1'b0, magic[15:8]});
        byte_reqs.push_back({1'b0, magic[23:16]});
        byte_reqs.push_back({1'b0, magic[31:24]});
        for (int k = 0; k < 4; k++) byte_reqs.push_back({1'b0, dlen[8 * k +: 8]});
        foreach (img[k]) byte_reqs.push_back({1'b0, img[k]});
        // trailing bytes are swallowed by the parser unless one carries i_first_byte, which restarts it
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) byte_reqs.push_back({1'($urandom), 8'($urandom)});
    endtask

    // ---------------------------------------------------------------- checking
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        $display("MISMATCH %s: got %h want %h", what, got, want);
    endtask

    // Outputs are checked before the byte accepted on this edge is predicted,
    // so the output always matches the oldest pending expectation.
    always @(posedge i_clk) begin
        t_field_rec w;
        if (i_rst_n && o_valid && i_ready) begin
            if (field_q.size() == 0) report_mismatch("unexpected request", o_field_value, 0);
            else begin
                w = field_q.pop_front();
                if (o_section != w.section) report_mismatch("section", o_section, w.section);
                if (o_field_code != w.field_code)
                    report_mismatch("field_code", o_field_code, w.field_code);
                if (o_record_index != w.record_index)
                    report_mismatch("record_index", o_record_index, w.record_index);
                if (o_field_value != w.field_value)
                    report_mismatch("field_value", o_field_value, w.field_value);
                if (o_derived_edge != w.derived_edge)
                    report_mismatch("derived_edge", o_derived_edge, w.derived_edge);
                if (o_tile_rgba != w.tile_rgba)
                    report_mismatch("tile_rgba", o_tile_rgba, w.tile_rgba);
                if (o_error_code != w.error_code)
                    report_mismatch("error_code", o_error_code, w.error_code);
                if (o_scene_done != w.scene_done)
                    report_mismatch("scene_done", o_scene_done, w.scene_done);
            end
        end
        if (i_rst_n && i_valid && o_ready) begin
            predict_byte(i_data_byte, i_first_byte);
            taken = 1'b1;
        end
    end

    // ---------------------------------------------------------------- driver
    // Falling edge: present the next byte once the last one was taken; the
    // idle/stall mix steps through four phases over the run.
    always @(negedge i_clk) begin
        logic [8:0] nxt;
        bit hold;
        if (i_rst_n) begin
            phase = (total_items > 0) ? (issued * 4 / total_items) % 4 : 0;
            i_ready <= ($urandom_range(0, 99) >= stall_pct[phase]);
            if (!i_valid || taken) begin
                taken = 1'b0;
                // one pause until the output side has drained completely
                hold = (issued == pause_at) && (field_q.size() != 0 || o_valid);
                if (byte_reqs.size() != 0 && !hold &&
                    $urandom_range(0, 99) >= idle_pct[phase]) begin
                    nxt = byte_reqs.pop_front();
                    i_first_byte <= nxt[8];
                    i_data_byte <= nxt[7:0];
                    i_valid <= 1'b1;
                    issued++;
                end else i_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- sequence
    initial begin
        clear_parse();
        // directed: empty scene, bad magic and a stray byte, then a random mix of damage kinds
        build_scene(FL_NONE, 1'b1);
        build_scene(FL_MAGIC, 1'b1);
        byte_reqs.push_back({1'b0, 8'hFF});
        while (byte_reqs.size() < 1150) begin
            case ($urandom_range(0, 15))
                0: build_scene(FL_MAGIC, 1'b0);
                1: build_scene(FL_TRUNC, 1'b0);
                2: build_scene(FL_TILETYPE, 1'b0);
                3: build_scene(FL_COMPR, 1'b0);
                4: build_scene(FL_POOL, 1'b0);
                5: build_scene(FL_HANDLE, 1'b0);
                6: build_scene(FL_COLOROVF, 1'b0);
                7: build_scene(FL_NOISE, 1'b0);
                default: build_scene(FL_NONE, 1'b0);
            endcase
        end
        total_items = byte_reqs.size();
        pause_at = total_items / 3;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (byte_reqs.size() != 0 || i_valid) @(posedge i_clk);
        while (field_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (err_count == 0) $display("tb_scene_record_stream_parser: clean");
        else $display("tb_scene_record_stream_parser: errors");
        $finish;
    end

    initial begin
        #400000;
        $display("tb_scene_record_stream_parser: errors");
        $finish;
    end
endmodule
`default_nettype wire
